/* rtl/rpy_pkg.sv */
// Shared constants, flag type and output saturation for the RGB to perceptual YUV core.
// No dependencies; every other file uses it by scoped names.
package rpy_pkg;

    localparam int QBITS = 16;          // quotient bits per result

    // Colour weights in units of 1/1024
    localparam int W_Y_R = 306;
    localparam int W_Y_G = 601;
    localparam int W_Y_B = 117;
    localparam int W_U   = 136;
    localparam int W_V_R = 169;         // subtracted
    localparam int W_V_G = 39;
    localparam int W_V_B = 130;

    // (1 + 1/32) scaled into Q2.14 with the 1/1024 weight scale: 33 * 512
    localparam int CHROMA_GAIN = 16896;

    localparam int BIAS_SHIFT  = 5;     // max/32 bias, taken in 1/1024 units
    localparam int CLAMP_SHIFT = 4;     // max/64 floor of the denominator
    localparam int LUMA_SHIFT  = 6;     // 2 * 32 for Q1.15 with a half-step bias

    localparam logic [15:0] MAX_SAMPLE_RST = 16'd255;

    typedef struct packed {
        logic ovf;                      // quotient does not fit in QBITS
        logic neg;                      // numerator was negative
    } t_lane_flags;

    function automatic logic [15:0] sat_luma(input logic [15:0] q, input t_lane_flags f);
        logic [15:0] res;
        res = f.ovf ? 16'hFFFF : q;
        return res;
    endfunction

    function automatic logic [15:0] sat_chroma(input logic [15:0] q, input t_lane_flags f);
        logic [15:0] res;
        if (f.neg) begin
            if (f.ovf || q > 16'd32768) begin
                res = 16'h8000;
            end else begin
                res = 16'd0 - q;
            end
        end else begin
            if (f.ovf || q > 16'd32767) begin
                res = 16'h7FFF;
            end else begin
                res = q;
            end
        end
        return res;
    endfunction

endpackage

/* rtl/rpy_front.sv */
// Front end: weighted sums, chroma gain and denominator, two register stages.
// Uses rpy_pkg for weights and shift constants.
module rpy_front #(
    parameter int SB = 16
) (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [SB-1:0]     i_red,
    input  logic [SB-1:0]     i_green,
    input  logic [SB-1:0]     i_blue,
    input  logic [SB-1:0]     i_max,
    output logic [SB+10:0]    o_den,
    output logic [SB+22:0]    o_prod_u,
    output logic [SB+22:0]    o_prod_v,
    output logic              o_neg_u,
    output logic              o_neg_v,
    output logic [SB+16:0]    o_luma_num,
    output logic [SB-1:0]     o_max
);

    localparam int YW   = SB + 10;      // luma sum
    localparam int UW   = SB + 9;       // signed chroma sums
    localparam int MW   = UW - 1;       // chroma magnitude
    localparam int PW   = SB + 23;      // magnitude times gain
    localparam int DENW = SB + 11;
    localparam int LNW  = SB + 17;

    // stage 0
    logic [YW-1:0] r_ys, n_ys;
    logic [UW-1:0] r_us, n_us;
    logic [UW-1:0] r_vs, n_vs;
    logic [SB-1:0] r_mx, n_mx;

    // stage 1
    logic [DENW-1:0] r_den, n_den;
    logic [PW-1:0]   r_prod_u, n_prod_u;
    logic [PW-1:0]   r_prod_v, n_prod_v;
    logic            r_neg_u, r_neg_v;
    logic [LNW-1:0]  r_lnum, n_lnum;
    logic [SB-1:0]   r_mx1;

    logic [MW-1:0]   w_mag_u, w_mag_v;
    logic [DENW-1:0] w_den_a, w_den_min;

    always_comb begin
        n_ys = YW'(i_red) * YW'(rpy_pkg::W_Y_R)
             + YW'(i_green) * YW'(rpy_pkg::W_Y_G)
             + YW'(i_blue) * YW'(rpy_pkg::W_Y_B);
        // modular arithmetic, the true value always fits UW bits signed
        n_us = UW'(rpy_pkg::W_U) * (UW'(i_red) - UW'(i_green));
        n_vs = UW'(rpy_pkg::W_V_B) * UW'(i_blue)
             + UW'(rpy_pkg::W_V_G) * UW'(i_green)
             - UW'(rpy_pkg::W_V_R) * UW'(i_red);
        n_mx = (i_max == '0) ? SB'(1) : i_max;
    end

    always_comb begin
        w_mag_u   = r_us[UW-1] ? MW'(UW'(0) - r_us) : r_us[MW-1:0];
        w_mag_v   = r_vs[UW-1] ? MW'(UW'(0) - r_vs) : r_vs[MW-1:0];
        n_prod_u  = PW'(w_mag_u) * PW'(rpy_pkg::CHROMA_GAIN);
        n_prod_v  = PW'(w_mag_v) * PW'(rpy_pkg::CHROMA_GAIN);
        w_den_a   = DENW'(r_ys) + (DENW'(r_mx) << rpy_pkg::BIAS_SHIFT);
        w_den_min = DENW'(r_mx) << rpy_pkg::CLAMP_SHIFT;
        n_den     = (w_den_a < w_den_min) ? w_den_min : w_den_a;
        n_lnum    = (LNW'(r_ys) << rpy_pkg::LUMA_SHIFT) + LNW'(r_mx);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ys     <= n_ys;
            r_us     <= n_us;
            r_vs     <= n_vs;
            r_mx     <= n_mx;
            r_den    <= n_den;
            r_prod_u <= n_prod_u;
            r_prod_v <= n_prod_v;
            r_neg_u  <= r_us[UW-1];
            r_neg_v  <= r_vs[UW-1];
            r_lnum   <= n_lnum;
            r_mx1    <= r_mx;
        end
    end

    assign o_den      = r_den;
    assign o_prod_u   = r_prod_u;
    assign o_prod_v   = r_prod_v;
    assign o_neg_u    = r_neg_u;
    assign o_neg_v    = r_neg_v;
    assign o_luma_num = r_lnum;
    assign o_max      = r_mx1;

endmodule

/* rtl/rpy_div_cell.sv */
// One restoring-division step: shift in a numerator bit, subtract if it fits, register.
// Uses rpy_pkg for the quotient width and lane flags.
module rpy_div_cell #(
    parameter int DW = 28
) (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [DW-1:0]                i_rem,
    input  logic [DW-1:0]                i_div,
    input  logic [rpy_pkg::QBITS-1:0]    i_nq,
    input  rpy_pkg::t_lane_flags         i_flags,
    output logic [DW-1:0]                o_rem,
    output logic [DW-1:0]                o_div,
    output logic [rpy_pkg::QBITS-1:0]    o_nq,
    output rpy_pkg::t_lane_flags         o_flags
);

    logic [DW:0]                   w_part;
    logic                          w_fit;
    logic [DW-1:0]                 r_rem, n_rem;
    logic [DW-1:0]                 r_div;
    logic [rpy_pkg::QBITS-1:0]     r_nq, n_nq;
    rpy_pkg::t_lane_flags          r_flags;

    // numerator bits leave at the top of nq while quotient bits enter at the bottom
    always_comb begin
        w_part = {i_rem, i_nq[rpy_pkg::QBITS-1]};
        w_fit  = w_part >= {1'b0, i_div};
        n_rem  = w_fit ? DW'(w_part - {1'b0, i_div}) : w_part[DW-1:0];
        n_nq   = {i_nq[rpy_pkg::QBITS-2:0], w_fit};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem   <= n_rem;
            r_div   <= i_div;
            r_nq    <= n_nq;
            r_flags <= i_flags;
        end
    end

    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_nq    = r_nq;
    assign o_flags = r_flags;

endmodule

/* rtl/rgb_to_perceptual_yuv_core.sv */
// Top level of the RGB to perceptual YUV converter: front end, division cell chain, output.
// Depends on rpy_pkg, rpy_front and rpy_div_cell.
//
//  channel   | valid / ready              | payload
//  ----------+----------------------------+-------------------------------------
//  pixel in  | i_valid / o_ready          | i_red, i_green, i_blue
//  result    | o_valid / i_ready          | o_luma, o_chroma_u, o_chroma_v
//  config    | i_cfg_valid / o_cfg_ready  | i_max_sample
//
//  One pixel per cycle unless the result side stalls; the 16 division cells (one quotient bit each)
//  follow two front stages and one setup stage, and feed the output register.
//  Reset (synchronous, active low) empties the pipeline and sets max_sample to 255.
//  The whole pipeline advances when the output register is empty or being taken;
//  o_ready follows that, so a stall on the result side holds every stage in place.
module rgb_to_perceptual_yuv_core #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [15:0] i_red,
    input  logic [15:0] i_green,
    input  logic [15:0] i_blue,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_luma,
    output logic signed [15:0] o_chroma_u,
    output logic signed [15:0] o_chroma_v,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_max_sample
);

    localparam int SB    = SAMPLE_BITS;
    localparam int QB    = rpy_pkg::QBITS;
    localparam int DENW  = SB + 11;
    localparam int PW    = SB + 23;
    localparam int LNW   = SB + 17;
    localparam int NCW   = SB + 25;     // chroma numerator
    localparam int DCW   = SB + 12;     // chroma divisor, twice the denominator
    localparam int LDW   = SB + 1;      // luma divisor, twice max_sample
    localparam int NST   = 3 + QB;      // stages ahead of the output register

    logic [15:0]    r_max_sample;
    logic [NST-1:0] r_vld;
    logic           r_out_valid;
    logic           w_adv;

    logic [DENW-1:0] w_den;
    logic [PW-1:0]   w_prod_u, w_prod_v;
    logic            w_neg_u, w_neg_v;
    logic [LNW-1:0]  w_lnum;
    logic [SB-1:0]   w_mx;

    logic [NCW-1:0]  w_num_u, w_num_v;
    logic [DCW-1:0]  w_dc;
    logic [LDW-1:0]  w_dl;
    logic [DCW-1:0]  w_hi_u, w_hi_v;
    logic [LDW-1:0]  w_hi_l;

    // setup stage registers, head of each cell chain
    logic [DCW-1:0]       r_rem_u0, r_div_u0, r_rem_v0, r_div_v0;
    logic [LDW-1:0]       r_rem_l0, r_div_l0;
    logic [QB-1:0]        r_nq_u0, r_nq_v0, r_nq_l0;
    rpy_pkg::t_lane_flags r_fl_u0, r_fl_v0, r_fl_l0;

    logic [DCW-1:0] w_rem_u [QB+1];
    logic [DCW-1:0] w_div_u [QB+1];
    logic [QB-1:0]  w_nq_u  [QB+1];
    rpy_pkg::t_lane_flags w_fl_u [QB+1];
    logic [DCW-1:0] w_rem_v [QB+1];
    logic [DCW-1:0] w_div_v [QB+1];
    logic [QB-1:0]  w_nq_v  [QB+1];
    rpy_pkg::t_lane_flags w_fl_v [QB+1];
    logic [LDW-1:0] w_rem_l [QB+1];
    logic [LDW-1:0] w_div_l [QB+1];
    logic [QB-1:0]  w_nq_l  [QB+1];
    rpy_pkg::t_lane_flags w_fl_l [QB+1];

    logic [15:0] r_luma, r_chroma_u, r_chroma_v;

    assign w_adv       = !r_out_valid || i_ready;
    assign o_ready     = w_adv;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_sample <= rpy_pkg::MAX_SAMPLE_RST;
        end else if (i_cfg_valid) begin
            r_max_sample <= i_max_sample;
        end
    end

    rpy_front #(.SB(SB)) u_front (
        .i_clk      (i_clk),
        .i_en       (w_adv),
        .i_red      (i_red[SB-1:0]),
        .i_green    (i_green[SB-1:0]),
        .i_blue     (i_blue[SB-1:0]),
        .i_max      (r_max_sample[SB-1:0]),
        .o_den      (w_den),
        .o_prod_u   (w_prod_u),
        .o_prod_v   (w_prod_v),
        .o_neg_u    (w_neg_u),
        .o_neg_v    (w_neg_v),
        .o_luma_num (w_lnum),
        .o_max      (w_mx)
    );

    // Setup: form the rounded numerators and flag quotients that overflow QB bits.
    // The top part of the numerator becomes the starting remainder.
    always_comb begin
        w_num_u = (NCW'(w_prod_u) << 1) + NCW'(w_den);
        w_num_v = (NCW'(w_prod_v) << 1) + NCW'(w_den);
        w_dc    = DCW'(w_den) << 1;
        w_dl    = LDW'(w_mx) << 1;
        w_hi_u  = DCW'(w_num_u[NCW-1:QB]);
        w_hi_v  = DCW'(w_num_v[NCW-1:QB]);
        w_hi_l  = w_lnum[LNW-1:QB];
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_rem_u0     <= w_hi_u;
            r_div_u0     <= w_dc;
            r_nq_u0      <= w_num_u[QB-1:0];
            r_fl_u0.ovf  <= w_hi_u >= w_dc;
            r_fl_u0.neg  <= w_neg_u;
            r_rem_v0     <= w_hi_v;
            r_div_v0     <= w_dc;
            r_nq_v0      <= w_num_v[QB-1:0];
            r_fl_v0.ovf  <= w_hi_v >= w_dc;
            r_fl_v0.neg  <= w_neg_v;
            r_rem_l0     <= w_hi_l;
            r_div_l0     <= w_dl;
            r_nq_l0      <= w_lnum[QB-1:0];
            r_fl_l0.ovf  <= w_hi_l >= w_dl;
            r_fl_l0.neg  <= 1'b0;
        end
    end

    assign w_rem_u[0] = r_rem_u0;
    assign w_div_u[0] = r_div_u0;
    assign w_nq_u[0]  = r_nq_u0;
    assign w_fl_u[0]  = r_fl_u0;
    assign w_rem_v[0] = r_rem_v0;
    assign w_div_v[0] = r_div_v0;
    assign w_nq_v[0]  = r_nq_v0;
    assign w_fl_v[0]  = r_fl_v0;
    assign w_rem_l[0] = r_rem_l0;
    assign w_div_l[0] = r_div_l0;
    assign w_nq_l[0]  = r_nq_l0;
    assign w_fl_l[0]  = r_fl_l0;

    for (genvar k = 0; k < QB; k++) begin : g_cell
        rpy_div_cell #(.DW(DCW)) u_cell_u (
            .i_clk(i_clk), .i_en(w_adv),
            .i_rem(w_rem_u[k]), .i_div(w_div_u[k]), .i_nq(w_nq_u[k]), .i_flags(w_fl_u[k]),
            .o_rem(w_rem_u[k+1]), .o_div(w_div_u[k+1]), .o_nq(w_nq_u[k+1]),
            .o_flags(w_fl_u[k+1])
        );
        rpy_div_cell #(.DW(DCW)) u_cell_v (
            .i_clk(i_clk), .i_en(w_adv),
            .i_rem(w_rem_v[k]), .i_div(w_div_v[k]), .i_nq(w_nq_v[k]), .i_flags(w_fl_v[k]),
            .o_rem(w_rem_v[k+1]), .o_div(w_div_v[k+1]), .o_nq(w_nq_v[k+1]),
            .o_flags(w_fl_v[k+1])
        );
        rpy_div_cell #(.DW(LDW)) u_cell_l (
            .i_clk(i_clk), .i_en(w_adv),
            .i_rem(w_rem_l[k]), .i_div(w_div_l[k]), .i_nq(w_nq_l[k]), .i_flags(w_fl_l[k]),
            .o_rem(w_rem_l[k+1]), .o_div(w_div_l[k+1]), .o_nq(w_nq_l[k+1]),
            .o_flags(w_fl_l[k+1])
        );
    end

    // Advance the valid chain with the data; bubbles move too
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_vld       <= {r_vld[NST-2:0], i_valid};
            r_out_valid <= r_vld[NST-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_luma     <= rpy_pkg::sat_luma(w_nq_l[QB], w_fl_l[QB]);
            r_chroma_u <= rpy_pkg::sat_chroma(w_nq_u[QB], w_fl_u[QB]);
            r_chroma_v <= rpy_pkg::sat_chroma(w_nq_v[QB], w_fl_v[QB]);
        end
    end

    assign o_valid    = r_out_valid;
    assign o_luma     = r_luma;
    assign o_chroma_u = r_chroma_u;
    assign o_chroma_v = r_chroma_v;

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> r_vld[0])
        else $error("accepted request did not enter the pipeline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_vld))
        else $error("pipeline moved during a stall");

    a_chain_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_vld[NST-1]) |=> o_valid)
        else $error("item leaving the cell chain was lost");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_max_sample == $past(i_max_sample)))
        else $error("max_sample write not taken");

endmodule
